// ===== src/ctwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctwm_pkg
// Shared widths, constants, controller states and the command/status bundles
// of the centered time-weighted mean block.
// ----------------------------------------------------------------------------
package ctwm_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned HW_W       = 9;
  localparam int unsigned WS_W       = 42;
  localparam int unsigned WT_W       = 26;
  localparam int unsigned RC_W       = 11;
  localparam int unsigned PO_W       = 10;
  localparam int unsigned TS_W       = 48;
  localparam int unsigned PROD_W     = SAMPLE_W + INTERVAL_W + 2;
  localparam int unsigned ENTRY_W    = SAMPLE_W + INTERVAL_W;

  localparam logic [HW_W-1:0] HW_RESET = HW_W'(500);
  localparam logic [RC_W-1:0] RC_MAX   = '1;
  localparam logic [PO_W-1:0] PO_MAX   = '1;

  // request function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_ADD,
    ST_RD_RET,
    ST_RD_CEN,
    ST_SUB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } ctwm_state_e;

  typedef struct packed {
    logic latch_in;
    logic write_smp;
    logic add_prod;
    logic rd_retire;
    logic rd_center;
    logic sub_retire;
    logic div_start;
    logic load_out;
  } ctwm_cmd_t;

  typedef struct packed {
    logic func;
    logic po_zero;
    logic emit_due;
    logic wt_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } ctwm_sts_t;

endpackage
`default_nettype wire

// ===== src/ctwm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctwm_div
// Restoring divider, one quotient bit per cycle: signed weighted sum over
// unsigned weight sum, truncated toward zero, saturated to 16 bits.
// ----------------------------------------------------------------------------
module ctwm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ctwm_pkg::WS_W-1:0]    dividend_i,
  input  wire logic [ctwm_pkg::WT_W-1:0]    divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [ctwm_pkg::SAMPLE_W-1:0]     quotient_o
);
  import ctwm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WS_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q;
  logic [WS_W-1:0]   quo_q;
  logic [WT_W-1:0]   rem_q;
  logic [WT_W-1:0]   dvs_q;

  logic [WS_W-1:0]   mag;
  logic [WT_W:0]     rem_shift;
  logic [WT_W:0]     rem_diff;
  logic              ge;
  logic [WT_W-1:0]   rem_d;
  logic [SAMPLE_W-1:0] neg_low;

  assign mag       = dividend_i[WS_W-1] ? (~dividend_i) + WS_W'(1) : dividend_i;
  assign rem_shift = {rem_q, quo_q[WS_W-1]};
  assign ge        = rem_shift >= {1'b0, dvs_q};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign rem_d     = ge ? rem_diff[WT_W-1:0] : rem_shift[WT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WS_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[WS_W-1];
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[WS_W-2:0], ge};
    end
  end

  // Saturate magnitude back into the signed 16-bit range.
  assign neg_low = (~quo_q[SAMPLE_W-1:0]) + SAMPLE_W'(1);

  always_comb begin
    if (neg_q) begin
      quotient_o = (quo_q > WS_W'(32768)) ? 16'h8000 : neg_low;
    end else begin
      quotient_o = (quo_q > WS_W'(32767)) ? 16'h7fff : quo_q[SAMPLE_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== src/ctwm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctwm_datapath
// Sample/interval ring, running sums, shared multiplier, divider and the
// output register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module ctwm_datapath #(
  parameter int unsigned RING_DEPTH = ctwm_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ctwm_pkg::HW_W-1:0]     cfg_wdata_i,
  input  wire logic                          func_i,
  input  wire logic [ctwm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [ctwm_pkg::INTERVAL_W-1:0] interval_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [ctwm_pkg::SAMPLE_W-1:0]      mean_o,
  output logic [ctwm_pkg::TS_W-1:0]          timestamp_o,
  output logic                               held_o,
  input  wire ctwm_pkg::ctwm_cmd_t           cmd_i,
  output ctwm_pkg::ctwm_sts_t                sts_o
);
  import ctwm_pkg::*;

  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
  localparam int unsigned KW     = (ADDR_W > RC_W) ? ADDR_W : RC_W;

  // control state
  logic [HW_W-1:0]     hw_q;
  logic [WS_W-1:0]     ws_q;
  logic [WT_W-1:0]     wt_q;
  logic [RC_W-1:0]     rc_q;
  logic [PO_W-1:0]     po_q;
  logic [SAMPLE_W-1:0] last_mean_q;
  logic [TS_W-1:0]     ct_q;
  logic [ADDR_W-1:0]   wp_q;
  logic                out_valid_q;

  // payload
  logic                  func_q;
  logic [SAMPLE_W-1:0]   smp_q;
  logic [INTERVAL_W-1:0] iv_q;
  logic [PROD_W-1:0]     prod_q;
  logic [ENTRY_W-1:0]    rd_q;
  logic                  retire_q;
  logic                  held_q;
  logic [SAMPLE_W-1:0]   mean_q;
  logic [TS_W-1:0]       ts_q;
  logic                  out_held_q;
  logic [ENTRY_W-1:0]    ring_q [RING_DEPTH];

  logic [KW-1:0]         ret_diff;
  logic [KW-1:0]         cen_diff;
  logic [ADDR_W-1:0]     rd_addr;
  logic [RC_W-1:0]       center;
  logic                  retire_now;
  logic [SAMPLE_W-1:0]   mul_a;
  logic [INTERVAL_W-1:0] mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic [WS_W-1:0]       prod_ext;
  logic [SAMPLE_W-1:0]   rd_smp;
  logic [INTERVAL_W-1:0] rd_iv;
  logic                  div_busy;
  logic                  div_done;
  logic [SAMPLE_W-1:0]   div_q;

  assign rd_smp = rd_q[ENTRY_W-1:INTERVAL_W];
  assign rd_iv  = rd_q[INTERVAL_W-1:0];

  // Ring positions: retiring entry is po+hw+1 behind, center is po behind.
  assign ret_diff = KW'(wp_q) - (KW'(po_q) + KW'(hw_q) + KW'(1));
  assign cen_diff = KW'(wp_q) - KW'(po_q);
  assign rd_addr  = cmd_i.rd_retire ? ret_diff[ADDR_W-1:0] : cen_diff[ADDR_W-1:0];

  assign center     = (rc_q >= RC_W'(po_q)) ? rc_q - RC_W'(po_q) : '0;
  assign retire_now = center >= (RC_W'(hw_q) + RC_W'(1));

  // Shared multiplier: new pair on write, retiring pair on read-back.
  assign mul_a    = cmd_i.write_smp ? smp_q : rd_smp;
  assign mul_b    = cmd_i.write_smp ? iv_q  : rd_iv;
  assign mul_p    = PROD_W'($signed({{2{mul_a[SAMPLE_W-1]}}, mul_a})
                          * $signed({2'b00, mul_b}));
  assign prod_ext = {{(WS_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= HW_RESET;
      ws_q        <= '0;
      wt_q        <= '0;
      rc_q        <= '0;
      po_q        <= '0;
      last_mean_q <= '0;
      ct_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hw_q <= cfg_wdata_i;
      end
      if (cmd_i.write_smp) begin
        if (rc_q == '0) begin
          last_mean_q <= smp_q;
        end
        wt_q <= wt_q + WT_W'(iv_q);
        wp_q <= wp_q + ADDR_W'(1);
        if (rc_q != RC_MAX) begin
          rc_q <= rc_q + RC_W'(1);
        end
        if (po_q != PO_MAX) begin
          po_q <= po_q + PO_W'(1);
        end
      end
      if (cmd_i.add_prod) begin
        ws_q <= ws_q + prod_ext;
      end
      if (cmd_i.rd_center && retire_q) begin
        wt_q <= wt_q - WT_W'(rd_iv);
      end
      if (cmd_i.sub_retire) begin
        if (retire_q) begin
          ws_q <= ws_q - prod_ext;
        end
        ct_q <= ct_q + TS_W'(rd_iv);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        if (!held_q) begin
          last_mean_q <= div_q;
        end
        if (po_q != '0) begin
          po_q <= po_q - PO_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= func_i;
      smp_q  <= sample_i;
      iv_q   <= interval_i;
    end
    if (cmd_i.write_smp || cmd_i.rd_center) begin
      prod_q <= mul_p;
    end
    if (cmd_i.rd_retire) begin
      retire_q <= retire_now;
    end
    if (cmd_i.div_start) begin
      held_q <= (wt_q == '0);
    end
    if (cmd_i.load_out) begin
      mean_q     <= held_q ? last_mean_q : div_q;
      ts_q       <= ct_q;
      out_held_q <= held_q;
    end
  end

  // Ring memory: one write or one read per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_smp) begin
      ring_q[wp_q] <= {smp_q, iv_q};
    end else if (cmd_i.rd_retire || cmd_i.rd_center) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  ctwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start && (wt_q != '0)),
    .dividend_i (ws_q),
    .divisor_i  (wt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    sts_o          = '0;
    sts_o.func     = func_q;
    sts_o.po_zero  = (po_q == '0);
    sts_o.emit_due = po_q > PO_W'(hw_q);
    sts_o.wt_zero  = (wt_q == '0);
    sts_o.div_busy = div_busy;
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign timestamp_o = ts_q;
  assign held_o      = out_held_q;

endmodule
`default_nettype wire

// ===== src/ctwm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctwm_ctrl
// Sequencer: decodes one request at a time and steps the datapath through
// store, accumulate, retire, center lookup, divide and output load.
// ----------------------------------------------------------------------------
module ctwm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ctwm_pkg::ctwm_sts_t  sts_i,
  output ctwm_pkg::ctwm_cmd_t       cmd_o
);
  import ctwm_pkg::*;

  ctwm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts_i.func) begin
          state_d = ST_WRITE;
        end else if (sts_i.po_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RD_RET;
        end
      end
      ST_WRITE: begin
        cmd_o.write_smp = 1'b1;
        state_d         = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_prod = 1'b1;
        state_d        = sts_i.emit_due ? ST_RD_RET : ST_IDLE;
      end
      ST_RD_RET: begin
        cmd_o.rd_retire = 1'b1;
        state_d         = ST_RD_CEN;
      end
      ST_RD_CEN: begin
        cmd_o.rd_center = 1'b1;
        state_d         = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub_retire = 1'b1;
        state_d          = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = sts_i.wt_zero ? ST_DONE : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/centered_time_weighted_mean.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// centered_time_weighted_mean
// Interval-weighted mean over a window centered on each sample.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): func_i = 0 brings a sample with its interval,
// func_i = 1 is a flush request that drains one owed result at stream end.
// Output channel (valid/ready): mean, cumulative timestamp of the center
// sample, and a held flag when the window weight was zero.
// One request is worked on at a time. A sample that owes no result passes
// through decode, write and accumulate before the next request is let in.
// A result runs on through retire read, center read, subtract, divider start,
// the bit-serial divider and the output load; a flush skips write and
// accumulate, and a zero window weight skips the divider. A flush with
// nothing pending goes back to idle straight from decode.
// The result sits in an output register: a stalled receiver holds it there
// while the next request is already taken in; the sequencer only waits at
// the final load if the previous result is still not taken.
// half_window is written through cfg_we_i/cfg_wdata_i; the user must do so only while the block is
// idle, the block does not enforce it. Reset (rst_ni low, asynchronous) clears sums, counters, pointers,
// and restores half_window to 500; ring contents are undefined until
// written and are never used before that.
// RING_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module centered_time_weighted_mean #(
  parameter int unsigned RING_DEPTH = ctwm_pkg::RING_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ctwm_pkg::HW_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            func_i,
  input  wire logic [ctwm_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic [ctwm_pkg::INTERVAL_W-1:0] interval_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [ctwm_pkg::SAMPLE_W-1:0]        mean_o,
  output logic [ctwm_pkg::TS_W-1:0]            timestamp_o,
  output logic                                 held_o
);
  import ctwm_pkg::*;

  // command and status between sequencer and datapath
  ctwm_cmd_t cmd;
  ctwm_sts_t sts;

  ctwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctwm_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .interval_i  (interval_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .mean_o      (mean_o),
    .timestamp_o (timestamp_o),
    .held_o      (held_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // a new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // one request in flight: ready drops right after acceptance
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request accepted while busy");

  // divider is only started when idle
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_start && !sts.wt_zero) |-> !sts.div_busy)
    else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

// ===== dv/ctwm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctwm_checker
// Watches both channels and the config port of the centered time-weighted
// mean block, keeps its own copy of the window state and compares every
// result field by field against the oldest owed expectation.
// ----------------------------------------------------------------------------
module ctwm_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ctwm_pkg::HW_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic                            func_i,
  input  wire logic [ctwm_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic [ctwm_pkg::INTERVAL_W-1:0] interval_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic [ctwm_pkg::SAMPLE_W-1:0]   mean_i,
  input  wire logic [ctwm_pkg::TS_W-1:0]       timestamp_i,
  input  wire logic                            held_i,
  output int                                   fail_count_o,
  output int                                   owed_count_o,
  output int                                   checked_count_o
);

  localparam int unsigned DEPTH = ctwm_pkg::RING_DEPTH_DEF;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = ctwm_pkg::SAMPLE_W;
  localparam int unsigned IW    = ctwm_pkg::INTERVAL_W;
  localparam int unsigned WS    = ctwm_pkg::WS_W;
  localparam int unsigned WT    = ctwm_pkg::WT_W;
  localparam int unsigned TW    = ctwm_pkg::TS_W;

  localparam logic FUNC_FLUSH = ctwm_pkg::FUNC_FLUSH;

  typedef struct packed {
    logic [SW-1:0] mean;
    logic [TW-1:0] stamp;
    logic          held;
  } center_mean_t;

  logic [SW-1:0]                 smp_ring [DEPTH];
  logic [IW-1:0]                 ivl_ring [DEPTH];
  logic [WS-1:0]                 sum_prod;
  logic [WT-1:0]                 sum_wt;
  logic [ctwm_pkg::RC_W-1:0]     n_received;
  logic [ctwm_pkg::PO_W-1:0]     n_owed;
  logic [SW-1:0]                 last_good;
  logic [TW-1:0]                 center_ts;
  logic [AW-1:0]                 wr_ptr;
  logic [ctwm_pkg::HW_W-1:0]     half_win;

  center_mean_t owed_means [$];
  center_mean_t want;
  int n_fail    = 0;
  int n_checked = 0;
  int owed_left = 0;

  assign fail_count_o    = n_fail;
  assign owed_count_o    = owed_left;
  assign checked_count_o = n_checked;

  // sample times interval, full precision
  function automatic longint weighted(logic [SW-1:0] s, logic [IW-1:0] w);
    longint a;
    longint b;
    a = $signed(s);
    b = w;
    return a * b;
  endfunction

  // Emit the oldest pending center: drop the sample leaving its window,
  // advance the center timestamp, divide (or hold the last mean on zero weight).
  function automatic center_mean_t close_center();
    center_mean_t res;
    int unsigned  center;
    logic [AW-1:0] old_idx;
    logic [AW-1:0] mid_idx;
    longint       num;
    longint       den;
    longint       quot;
    longint       p;
    res    = '0;
    center = (n_received >= n_owed) ? n_received - n_owed : 0;
    if (center >= half_win + 1) begin
      old_idx  = wr_ptr - AW'(n_owed + half_win + 1);
      p        = weighted(smp_ring[old_idx], ivl_ring[old_idx]);
      sum_prod = sum_prod - p[WS-1:0];
      sum_wt   = sum_wt - ivl_ring[old_idx];
    end
    mid_idx   = wr_ptr - AW'(n_owed);
    center_ts = center_ts + ivl_ring[mid_idx];
    if (sum_wt == '0) begin
      res.held = 1'b1;
      res.mean = last_good;
    end else begin
      num  = $signed(sum_prod);
      den  = sum_wt;
      quot = num / den;
      if (quot > 32767) quot = 32767;
      else if (quot < -32768) quot = -32768;
      res.mean  = quot[SW-1:0];
      last_good = res.mean;
    end
    res.stamp = center_ts;
    if (n_owed != '0) n_owed = n_owed - 1'b1;
    return res;
  endfunction

  // append one expected result at the tail of the owed list
  function automatic void queue_owed(center_mean_t r);
    owed_means.insert(owed_means.size(), r);
  endfunction

  function automatic void take_request(logic f, logic [SW-1:0] s, logic [IW-1:0] w);
    longint p;
    if (f == FUNC_FLUSH) begin
      if (n_owed != '0) queue_owed(close_center());
    end else begin
      if (n_received == '0) last_good = s;
      smp_ring[wr_ptr] = s;
      ivl_ring[wr_ptr] = w;
      p        = weighted(s, w);
      sum_prod = sum_prod + p[WS-1:0];
      sum_wt   = sum_wt + w;
      wr_ptr   = wr_ptr + 1'b1;
      if (n_received != ctwm_pkg::RC_MAX) n_received = n_received + 1'b1;
      if (n_owed != ctwm_pkg::PO_MAX) n_owed = n_owed + 1'b1;
      if (n_owed > half_win) queue_owed(close_center());
    end
  endfunction

  // one line per mismatch, and count it
  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned exp_v);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d, t=%0t)",
             what, got, exp_v, n_checked, $realtime);
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_prod   = '0;
      sum_wt     = '0;
      n_received = '0;
      n_owed     = '0;
      last_good  = '0;
      center_ts  = '0;
      wr_ptr     = '0;
      half_win   = ctwm_pkg::HW_RESET;
      owed_means.delete();
      owed_left  = 0;
    end else begin
      if (cfg_we_i) half_win = cfg_wdata_i;
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (owed_means.size() == 0) begin
          flag_mismatch("result with nothing owed", mean_i, 0);
        end else begin
          want = owed_means.pop_front();
          if (mean_i !== want.mean) flag_mismatch("mean", mean_i, want.mean);
          if (timestamp_i !== want.stamp) flag_mismatch("timestamp", timestamp_i, want.stamp);
          if (held_i !== want.held) flag_mismatch("held", held_i, want.held);
        end
        n_checked++;
      end
      if (in_valid_i && in_ready_i) take_request(func_i, sample_i, interval_i);
      owed_left = owed_means.size();
    end
  end

endmodule

// ===== dv/tb_centered_time_weighted_mean.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_centered_time_weighted_mean
// Drives sample and flush requests into the centered time-weighted mean
// block across several half_window settings, with random idling on both
// channels, and leaves all checking to ctwm_checker.
// ----------------------------------------------------------------------------
module tb_centered_time_weighted_mean;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE       = 64;
  localparam int HOLD_AT      = 200;   // result count that starts the long stall
  localparam int HOLD_OFF     = 400;
  localparam int STALL_LIMIT  = 3000;

  localparam logic FUNC_SAMPLE = ctwm_pkg::FUNC_SAMPLE;
  localparam logic FUNC_FLUSH  = ctwm_pkg::FUNC_FLUSH;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [ctwm_pkg::HW_W-1:0]       cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            func_i;
  logic [ctwm_pkg::SAMPLE_W-1:0]   sample_i;
  logic [ctwm_pkg::INTERVAL_W-1:0] interval_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [ctwm_pkg::SAMPLE_W-1:0]   mean_o;
  logic [ctwm_pkg::TS_W-1:0]       timestamp_o;
  logic                            held_o;

  int fail_count;
  int owed_count;
  int checked_count;

  // idle probabilities in percent, changed per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_requests  = 0;
  int mid_hw      = 0;

  centered_time_weighted_mean i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .interval_i  (interval_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mean_o      (mean_o),
    .timestamp_o (timestamp_o),
    .held_o      (held_o)
  );

  ctwm_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .func_i          (func_i),
    .sample_i        (sample_i),
    .interval_i      (interval_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mean_i          (mean_o),
    .timestamp_i     (timestamp_o),
    .held_i          (held_o),
    .fail_count_o    (fail_count),
    .owed_count_o    (owed_count),
    .checked_count_o (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Offer one request and hold it until taken. An idle burst, when drawn,
  // drops valid first; otherwise valid stays up and only the payload moves.
  task automatic push_request(input logic f, input logic [15:0] s, input logic [15:0] w);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    sample_i   <= s;
    interval_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    n_requests++;
  endtask

  // Stop offering, wait for every owed result, then give a request that
  // owes nothing time to leave the block. Checked at the falling edge so
  // the checker's bookkeeping for this edge is complete.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (owed_count != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_half_window(input logic [ctwm_pkg::HW_W-1:0] hw);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly full-range samples, with the extremes and zero mixed in
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // zero_pct steers how often a zero weight shows up (held results)
  function automatic logic [15:0] pick_interval(input int zero_pct);
    if ($urandom_range(99) < zero_pct) return 16'h0000;
    if ($urandom_range(9) == 0) return 16'hffff;
    return 16'($urandom);
  endfunction

  // flush_pct of 100 gives a pure drain; flush payload is don't-care
  task automatic random_requests(input int count, input int flush_pct, input int zero_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < flush_pct)
        push_request(FUNC_FLUSH, 16'($urandom), 16'($urandom));
      else
        push_request(FUNC_SAMPLE, pick_sample(), pick_interval(zero_pct));
    end
  endtask

  // receiver: random not-ready bursts, plus one long hold-off that lets the
  // output register and the sequencer fill so the input side backs up
  initial begin : receiver
    int burst;
    int taken;
    bit held_off;
    burst    = 0;
    taken    = 0;
    held_off = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      if (!held_off && taken == HOLD_AT) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end else if (burst != 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        burst = $urandom_range(11, 1) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TIMEOUT: nothing moved for %0d cycles, %0d results still owed",
             STALL_LIMIT, owed_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_SAMPLE;
    sample_i    <= '0;
    interval_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, half_window 2.
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    set_half_window(2);
    // flush before any sample: nothing pending, no result
    push_request(FUNC_FLUSH, 16'h7fff, 16'hffff);
    // zero-weight start: first result holds the first sample as its mean
    push_request(FUNC_SAMPLE, 16'h8000, 16'h0000);
    push_request(FUNC_SAMPLE, 16'h7fff, 16'h0000);
    push_request(FUNC_SAMPLE, 16'h0000, 16'h0000);
    // full-scale weights with both sample extremes
    push_request(FUNC_SAMPLE, 16'h7fff, 16'hffff);
    push_request(FUNC_SAMPLE, 16'h8000, 16'hffff);
    push_request(FUNC_SAMPLE, 16'hffff, 16'h0001);
    push_request(FUNC_SAMPLE, 16'h0001, 16'hffff);
    push_request(FUNC_SAMPLE, 16'h5555, 16'haaaa);
    push_request(FUNC_SAMPLE, 16'haaaa, 16'h5555);
    // drain the two owed centers at stream end, then two flushes too many
    repeat (3) push_request(FUNC_FLUSH, 16'h0000, 16'h0000);
    push_request(FUNC_FLUSH, 16'hffff, 16'hffff);
    // the stream carries on after a flush
    push_request(FUNC_SAMPLE, 16'd100, 16'd3);
    push_request(FUNC_SAMPLE, 16'hff9c, 16'h0000);
    push_request(FUNC_SAMPLE, 16'd7, 16'h0000);
    repeat (4) push_request(FUNC_FLUSH, 16'($urandom), 16'($urandom));

    // half_window zero: the window is the center alone, many zero weights
    set_half_window(0);
    tx_idle_pct = 30;
    rx_idle_pct = 10;
    random_requests(150, 8, 40);

    // half_window 1; the long output stall lands in here
    set_half_window(1);
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    random_requests(150, 8, 25);

    mid_hw = $urandom_range(40, 3);
    set_half_window(9'(mid_hw));
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    random_requests(250, 6, 10);

    // widest window: fill it, then drain every owed center
    set_half_window(9'd511);
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    random_requests(560, 0, 5);
    random_requests(513, 100, 0);

    // closing stretch at full rate on both sides
    set_half_window(9'd7);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_requests(150, 8, 10);

    wait_idle();
    $display("Summary: %0d requests sent, %0d results checked, %0d mismatches",
             n_requests, checked_count, fail_count);
    $display("Windows 2, 0, 1, %0d, 511, 7 with zero-weight holds, idle flushes, full drain",
             mid_hw);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
